// ===== rtl/sirt_pkg.sv =====
// Shared constants, codes and command/status types for the custom-radix text converter.
`timescale 1ns / 1ps

package sirt_pkg;

  // Alphabet storage and conversion sizes.
  localparam int ALPHABET_DEPTH = 256;
  localparam int MAX_DIGITS     = 32;
  localparam int MIN_SYMBOLS    = 2;
  localparam int NUM_W          = 32;
  localparam int SYM_W          = 8;
  localparam int ADDR_W         = $clog2(ALPHABET_DEPTH);
  localparam int COUNT_W        = $clog2(ALPHABET_DEPTH) + 1;
  localparam int DEPTH_W        = $clog2(MAX_DIGITS) + 1;
  localparam int STACK_AW       = $clog2(MAX_DIGITS);

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Reserved symbol bytes.
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  // Input action codes; the fourth code is ignored.
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_CONVERT = 2'd2
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv_start;
    logic div_step;
    logic look;
    logic store;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;
    logic mag_zero;
    logic out_free;
    logic emit_final;
  } dp_status_t;

endpackage

// ===== rtl/sirt_in_if.sv =====
// Input channel: one action beat with symbol and number payload.
`timescale 1ns / 1ps

interface sirt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  symbol;
  logic signed [31:0] number;

  modport source (output valid, output action, output symbol, output number, input ready);
  modport sink   (input valid, input action, input symbol, input number, output ready);
endinterface

// ===== rtl/sirt_out_if.sv =====
// Output channel: one character beat with a last mark.
`timescale 1ns / 1ps

interface sirt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/sirt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sirt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sirt_dp.sv =====
// Datapath: alphabet tables, radix divider, digit stack and output register.
`timescale 1ns / 1ps

module sirt_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sirt_pkg::ctrl_cmd_t      cmd_i,
  input  logic [1:0]               action_i,
  input  logic [sirt_pkg::SYM_W-1:0] symbol_i,
  input  logic signed [sirt_pkg::NUM_W-1:0] number_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [sirt_pkg::SYM_W-1:0] out_char_o,
  output logic                     out_last_o,
  output sirt_pkg::dp_status_t     status_o
);
  import sirt_pkg::*;

  logic [ALPHABET_DEPTH-1:0] seen_q, seen_d, seen_base;
  logic [COUNT_W-1:0]        count_q, count_d, count_base;
  logic                      bad_q, bad_d, bad_base;
  logic                      ram_we;
  logic [SYM_W-1:0]          ram_rdata;

  logic [NUM_W-1:0]          mag_q, mag_d;
  logic [SYM_W-1:0]          rem_q, rem_d;
  logic                      neg_pend_q;
  logic [DEPTH_W-1:0]        depth_q;
  logic [SYM_W-1:0]          stack_q [MAX_DIGITS];
  logic [STACK_AW-1:0]       rd_idx;

  logic                      out_valid_q;
  logic [SYM_W-1:0]          out_char_q;
  logic                      out_last_q;

  // Alphabet load: start clears the set, then the symbol is checked and appended.
  always_comb begin
    if (action_i == ACT_START) begin
      seen_base  = '0;
      count_base = '0;
      bad_base   = 1'b0;
    end else begin
      seen_base  = seen_q;
      count_base = count_q;
      bad_base   = bad_q;
    end
    seen_d  = seen_q;
    count_d = count_q;
    bad_d   = bad_q;
    ram_we  = 1'b0;
    if (cmd_i.load) begin
      seen_d  = seen_base;
      count_d = count_base;
      bad_d   = bad_base;
      if (!bad_base) begin
        if (seen_base[symbol_i] || symbol_i == SYM_PLUS || symbol_i == SYM_MINUS) begin
          bad_d = 1'b1;
        end else if (count_base >= COUNT_W'(ALPHABET_DEPTH)) begin
          bad_d = 1'b1;
        end else begin
          seen_d[symbol_i] = 1'b1;
          ram_we           = 1'b1;
          count_d          = count_base + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      count_q <= count_d;
      bad_q   <= bad_d;
    end
  end

  // Symbol store, written at the fill position and read by digit value.
  sirt_ram #(
    .WIDTH (SYM_W),
    .DEPTH (ALPHABET_DEPTH)
  ) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_base[ADDR_W-1:0]),
    .wdata_i (symbol_i),
    .re_i    (cmd_i.look),
    .raddr_i (rem_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // One divider step: DIV_BITS restoring shift-subtract bits by the radix.
  always_comb begin
    logic [SYM_W:0]   trial;
    logic [SYM_W-1:0] r;
    logic [NUM_W-1:0] m;
    r = rem_q;
    m = mag_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r, m[NUM_W-1]};
      m     = {m[NUM_W-2:0], 1'b0};
      if (trial >= count_q) begin
        trial = trial - count_q;
        m[0]  = 1'b1;
      end
      r = trial[SYM_W-1:0];
    end
    mag_d = m;
    rem_d = r;
  end

  assign rd_idx = depth_q[STACK_AW-1:0] - STACK_AW'(1);

  // Conversion registers: magnitude, remainder, sign and digit stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_pend_q <= 1'b0;
      depth_q    <= '0;
    end else begin
      if (cmd_i.conv_start) begin
        neg_pend_q <= number_i[NUM_W-1];
        depth_q    <= '0;
      end else if (cmd_i.store) begin
        depth_q <= depth_q + DEPTH_W'(1);
      end else if (cmd_i.emit) begin
        if (neg_pend_q) begin
          neg_pend_q <= 1'b0;
        end else begin
          depth_q <= depth_q - DEPTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      mag_q <= number_i[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number_i)) : NUM_W'(number_i);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end else if (cmd_i.store) begin
      rem_q <= '0;
    end
    if (cmd_i.store) begin
      stack_q[depth_q[STACK_AW-1:0]] <= ram_rdata;
    end
  end

  // Output register: the minus sign first, then digits from the top of the stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (neg_pend_q) begin
        out_char_q <= SYM_MINUS;
        out_last_q <= 1'b0;
      end else begin
        out_char_q <= stack_q[rd_idx];
        out_last_q <= (depth_q == DEPTH_W'(1));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  assign status_o.alpha_ok   = !bad_q && (count_q >= COUNT_W'(MIN_SYMBOLS));
  assign status_o.mag_zero   = (mag_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.emit_final = !neg_pend_q && (depth_q == DEPTH_W'(1));

endmodule

// ===== rtl/sirt_ctrl.sv =====
// Controller: sequences loads, digit division, symbol lookup and character output.
`timescale 1ns / 1ps

module sirt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_action_i,
  output logic                 in_ready_o,
  input  sirt_pkg::dp_status_t status_i,
  output sirt_pkg::ctrl_cmd_t  cmd_o
);
  import sirt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_STORE,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              in_fire;
  logic              is_load;
  logic              is_conv;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_load    = (in_action_i == ACT_START) || (in_action_i == ACT_APPEND);
  assign is_conv    = (in_action_i == ACT_CONVERT);

  // Command decode from the current state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = in_fire && is_load;
    cmd_o.conv_start = in_fire && is_conv && status_i.alpha_ok;
    cmd_o.div_step   = (state_q == ST_DIV);
    cmd_o.look       = (state_q == ST_LOOK);
    cmd_o.store      = (state_q == ST_STORE);
    cmd_o.emit       = (state_q == ST_EMIT) && status_i.out_free;
  end

  // State register and divider step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_fire && is_conv && status_i.alpha_ok) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_STORE;
        end
        ST_STORE: begin
          step_q  <= '0;
          state_q <= status_i.mag_zero ? ST_EMIT : ST_DIV;
        end
        ST_EMIT: begin
          if (status_i.out_free && status_i.emit_final) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/signed_int_to_custom_radix_text.sv =====
// Top level of the signed integer to custom-radix text converter.
//
//  channel   | dir | fields                          | beat
//  ----------+-----+---------------------------------+-------------------------------
//  data_i    | in  | action[1:0] symbol[7:0] number  | one load or convert request
//  result_o  | out | character[7:0] last             | one output character
//
// A load beat is taken while idle. A convert of a value with D digits is
// accepted while idle, then per digit runs the divider steps of eight bits
// each, one symbol-store read and one stack write, then sends D characters
// (plus a minus sign first for a negative value) as the output side takes them.
// Reset clears the symbol set, count and invalid flag at once; the symbol store
// needs no clearing. A stalled result holds the output register and the
// character sequencer; data_i is ready only between conversions.
`timescale 1ns / 1ps

module signed_int_to_custom_radix_text (
  input  logic              clk_i,
  input  logic              rst_ni,
  sirt_in_if.sink           data_i,
  sirt_out_if.source        result_o
);
  import sirt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  sirt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (data_i.valid),
    .in_action_i (data_i.action),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sirt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (data_i.action),
    .symbol_i    (data_i.symbol),
    .number_i    (data_i.number),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_char_o  (result_o.character),
    .out_last_o  (result_o.last),
    .status_o    (status)
  );

  assign data_i.ready = in_ready;

  // A character that is not the last one is always followed by another beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.ready && !result_o.last |=> result_o.valid)
    else $error("character sequence broken before its last beat");

  // New requests are taken only after the previous number is fully emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_i.ready |-> !result_o.valid || result_o.last)
    else $error("request accepted while a number is still being emitted");

  // An accepted convert on a valid alphabet blocks the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_i.valid && data_i.ready && data_i.action == ACT_CONVERT && status.alpha_ok
    |=> !data_i.ready)
    else $error("convert did not start the conversion sequence");

  // A load leaves the controller idle, so the input stays open after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> data_i.ready)
    else $error("load beat stalled the input");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the signed integer to custom-radix text converter.
`timescale 1ns / 1ps

// Tracks the loaded alphabet and holds the characters each conversion should print.
class radix_text_checker;
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  logic [7:0]   digit_symbols [sirt_pkg::ALPHABET_DEPTH];
  logic [255:0] used_symbols;
  int unsigned  radix;
  bit           alphabet_invalid;
  char_beat_t   pending_chars [$];

  int unsigned errors;
  int unsigned loads;
  int unsigned converts;
  int unsigned silent_converts;
  int unsigned unused_actions;
  int unsigned chars_checked;
  int unsigned min_radix;
  int unsigned max_radix;

  function new();
    used_symbols     = '0;
    radix            = 0;
    alphabet_invalid = 1'b0;
    errors           = 0;
    loads            = 0;
    converts         = 0;
    silent_converts  = 0;
    unused_actions   = 0;
    chars_checked    = 0;
    min_radix        = sirt_pkg::ALPHABET_DEPTH;
    max_radix        = 0;
  endfunction

  function int unsigned pending();
    return pending_chars.size();
  endfunction

  // A repeated or reserved symbol spoils the alphabet until the next start.
  function void add_symbol(logic [7:0] sym);
    if (alphabet_invalid) return;
    if (used_symbols[sym] || sym == sirt_pkg::SYM_PLUS || sym == sirt_pkg::SYM_MINUS) begin
      alphabet_invalid = 1'b1;
      return;
    end
    if (radix >= sirt_pkg::ALPHABET_DEPTH) begin
      alphabet_invalid = 1'b1;
      return;
    end
    used_symbols[sym]    = 1'b1;
    digit_symbols[radix] = sym;
    radix++;
  endfunction

  // Spell a signed number in the current alphabet, most significant digit first.
  function void spell_number(logic [31:0] bits);
    logic [31:0] mag;
    logic [7:0]  digits [$];
    bit          negative;
    negative = bits[31];
    mag      = negative ? -bits : bits;
    converts++;
    if (alphabet_invalid || radix < sirt_pkg::MIN_SYMBOLS) begin
      silent_converts++;
      return;
    end
    if (radix < min_radix) min_radix = radix;
    if (radix > max_radix) max_radix = radix;
    do begin
      digits.push_front(digit_symbols[mag % radix]);
      mag = mag / radix;
    end while (mag != 0);
    if (negative) pending_chars.push_back('{character: sirt_pkg::SYM_MINUS, last: 1'b0});
    foreach (digits[i]) begin
      pending_chars.push_back('{character: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  // Note one accepted input beat.
  function void note_input(logic [1:0] action, logic [7:0] symbol, logic [31:0] number);
    case (action)
      sirt_pkg::ACT_START: begin
        used_symbols     = '0;
        radix            = 0;
        alphabet_invalid = 1'b0;
        add_symbol(symbol);
        loads++;
      end
      sirt_pkg::ACT_APPEND: begin
        add_symbol(symbol);
        loads++;
      end
      sirt_pkg::ACT_CONVERT: spell_number(number);
      default: unused_actions++;
    endcase
  endfunction

  // Compare one accepted output beat with the oldest expected character.
  function void check_result(logic [7:0] character, logic last);
    char_beat_t exp_beat;
    if (pending_chars.size() == 0) begin
      $error("unexpected character beat: character %h, last %b", character, last);
      errors++;
      return;
    end
    exp_beat = pending_chars.pop_front();
    chars_checked++;
    if (character !== exp_beat.character) begin
      $error("character: expected %h, got %h", exp_beat.character, character);
      errors++;
    end
    if (last !== exp_beat.last) begin
      $error("last: expected %b, got %b", exp_beat.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  import sirt_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS   = 400;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         TAIL_CYCLES    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   no_idle = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;

  sirt_in_if  data_if ();
  sirt_out_if result_if ();

  radix_text_checker sb = new();

  signed_int_to_custom_radix_text DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (data_if),
    .result_o (result_if)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watch both channels: score every beat and stop a hung run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        sb.check_result(result_if.character, result_if.last);
      end
      if (data_if.valid && data_if.ready) begin
        sb.note_input(data_if.action, data_if.symbol, data_if.number);
      end
      if ((result_if.valid && result_if.ready) || (data_if.valid && data_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("signed_int_to_custom_radix_text verification failed");
        $finish;
      end
    end
  end

  // Output side: stall a random number of cycles before taking each character.
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  // Send one beat after a random gap and hold it until the block takes it.
  task automatic send_item(input logic [1:0] act, input logic [7:0] sym,
                           input logic [31:0] num);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_if.valid  <= 1'b1;
    data_if.action <= act;
    data_if.symbol <= sym;
    data_if.number <= num;
    do @(posedge clk_i); while (!data_if.ready);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // Hold the input side until every expected character has come out.
  task automatic wait_for_all_text();
    data_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly random values, with small numbers and the extremes mixed in.
  function automatic logic [31:0] random_number();
    logic [31:0] value;
    case ($urandom_range(0, 7))
      0: value = $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h0000_0000;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
      default: value = $urandom;
    endcase
    return value;
  endfunction

  // Load n distinct legal symbols; optionally spoil the alphabet at a random point.
  task automatic load_alphabet(input int n, input bit spoil);
    logic [7:0] pool [$];
    logic [7:0] tmp;
    logic [7:0] sym;
    int         j;
    int         bad_at;
    for (int b = 0; b < 256; b++) begin
      if (b != SYM_PLUS && b != SYM_MINUS) pool.push_back(8'(b));
    end
    for (int i = pool.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    bad_at = spoil ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      sym = pool[i];
      if (i == bad_at) begin
        case ($urandom_range(0, 2))
          0: sym = SYM_PLUS;
          1: sym = SYM_MINUS;
          default: sym = (i > 0) ? pool[$urandom_range(0, i - 1)] : SYM_PLUS;
        endcase
      end
      send_item((i == 0) ? ACT_START : ACT_APPEND, sym, $urandom);
    end
  endtask

  // Main sequence: reset, directed cases, random rounds, drain and report.
  initial begin
    int n;
    int pick;
    int target;
    rst_ni         <= 1'b0;
    data_if.valid  <= 1'b0;
    data_if.action <= ACT_START;
    data_if.symbol <= '0;
    data_if.number <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Convert with no alphabet, then with a single symbol.
    send_item(ACT_CONVERT, 8'h00, 32'd123);
    send_item(ACT_START, 8'h7A, 32'h0);
    send_item(ACT_CONVERT, 8'h00, -32'sd5);

    // Binary alphabet built from the zero byte and 0xFF: extremes of the number.
    send_item(ACT_START, 8'h00, 32'h0);
    send_item(ACT_APPEND, 8'hFF, 32'hFFFF_FFFF);
    send_item(ACT_CONVERT, 8'hFF, 32'h8000_0000);
    send_item(ACT_CONVERT, 8'h00, 32'h7FFF_FFFF);
    send_item(ACT_CONVERT, 8'h00, 32'h0000_0000);
    send_item(ACT_CONVERT, 8'h00, 32'hFFFF_FFFF);

    // Grow to base three, then spoil it with a plus sign.
    send_item(ACT_APPEND, 8'h71, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'h8000_0000);
    send_item(ACT_CONVERT, 8'h00, 32'd7);
    send_item(ACT_APPEND, SYM_PLUS, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'd1);
    send_item(ACT_APPEND, 8'h72, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'd2);

    // Duplicate symbol, and a minus sign as the first symbol.
    send_item(ACT_START, 8'h61, 32'h0);
    send_item(ACT_APPEND, 8'h61, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'd3);
    send_item(ACT_START, SYM_MINUS, 32'h0);
    send_item(ACT_APPEND, 8'h62, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'd4);

    // Unused action code, then a fresh binary alphabet with the largest value.
    send_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_item(ACT_START, 8'h01, 32'h0);
    send_item(ACT_APPEND, 8'h80, 32'h0);
    send_item(ACT_CONVERT, 8'h00, 32'h7FFF_FFFF);
    wait_for_all_text();

    // Random rounds: load an alphabet, then convert a few numbers with some noise.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 3) begin
        n = $urandom_range(100, 254);
      end else if (pick < 13) begin
        n = 1;
      end else begin
        n = $urandom_range(2, 16);
      end
      // Keep the total close to the planned item count.
      if (n > target - items_sent) n = target - items_sent;
      load_alphabet(n, $urandom_range(0, 6) == 0);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 19))
          0: send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), $urandom);
          1: send_item(ACT_APPEND, 8'($urandom_range(0, 255)), $urandom);
          default: send_item(ACT_CONVERT, 8'($urandom_range(0, 255)), random_number());
        endcase
      end
      if ($urandom_range(0, 9) == 0) wait_for_all_text();
    end

    // Drain, then give any stray character time to show up.
    no_idle = 1'b0;
    wait_for_all_text();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input beats: %0d symbol loads, %0d conversions (%0d silent),",
             sb.loads + sb.converts + sb.unused_actions, sb.loads, sb.converts,
             sb.silent_converts);
    $display("%0d unused-action beats; checked %0d output characters with radix %0d to %0d.",
             sb.unused_actions, sb.chars_checked, sb.min_radix, sb.max_radix);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signed_int_to_custom_radix_text verification clean");
    end else begin
      $display("signed_int_to_custom_radix_text verification failed");
    end
    $finish;
  end
endmodule
